// File: hw/rtl/lrft_pkg.sv
// Package for the LOD residency fade table: sizes, result kinds, opcodes.
// No dependencies.
`default_nettype none
package lrft_pkg;
  localparam int ENTRIES = 32;
  localparam int LEVELS = 8;
  localparam int COORD_BITS = 24;
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W = 3 + 2 * COORD_BITS;
  localparam int STAT_W = 16;
  localparam logic [15:0] FADE_FULL = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_FINISH = 2'd1,
    OP_MARK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    K_LOAD = 4'd0, K_KNOWN = 4'd1, K_FULL = 4'd2, K_MARKED = 4'd3,
    K_NOT_FOUND = 4'd4, K_DRAW = 4'd5, K_PENDING = 4'd6, K_RELEASE = 4'd7,
    K_DONE = 4'd8, K_RESIDENT = 4'd9, K_ABSENT = 4'd10
  } kind_t;
endpackage
`default_nettype wire

// File: hw/rtl/lrft_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lrft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/lod_residency_fade_table_core.sv
// Channel   Ports                                               Role
// in        in_valid/in_ready, in_opcode..in_time_step           requests
// out       out_valid/out_ready, out_kind..out_last              results
// cfg       cfg_valid/cfg_ready, cfg_data                        fade_rate
// Each request sweeps the table one slot at a time: RAM read (S_RD), then
// compare or fade and write back (S_EVAL). A finish first computes the fade step
// (S_STEP) and hands each valid slot's result to the output register (S_EMIT).
// No new request is taken until the sweep ends and the output register is empty.
// The sweep through key and fade RAMs sets the rate.
// Reset clears valid, selected and resident bits (flops); RAMs need no clear.
// Results wait in an output register; the sweep halts while it is full.
// Depends on lrft_pkg and lrft_ram.
`default_nettype none
module lod_residency_fade_table_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [2:0]  in_tile_level,
  input  wire logic signed [23:0] in_tile_x,
  input  wire logic signed [23:0] in_tile_z,
  input  wire logic [15:0] in_time_step,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_kind,
  output logic [2:0]       out_out_level,
  output logic signed [23:0] out_out_x,
  output logic signed [23:0] out_out_z,
  output logic [15:0]      out_fade_level,
  output logic             out_last
);
  import lrft_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_RD, S_EVAL, S_EMIT, S_END} state_t;

  state_t state_r;
  logic [15:0] rate_r;
  logic [ENTRIES-1:0] vld_r, sel_r, res_r;
  logic [1:0] op_r;
  logic [KEY_W-1:0] key_r;
  logic [31:0] prod_r;
  logic [15:0] step_r;
  logic [CNT_W-1:0] idx_r;
  logic found_r, free_r;
  logic [SLOT_W-1:0] fslot_r, free_slot_r;
  logic ov_r;
  logic [3:0] okind_r;
  logic [KEY_W-1:0] okey_r;
  logic [15:0] ofade_r;
  logic olast_r;

  // key and fade memories
  logic kwe, fwe;
  logic [SLOT_W-1:0] kwa, fwa, ra;
  logic [KEY_W-1:0] kwd, krd;
  logic [15:0] fwd, frd;
  lrft_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key (
    .clk, .we(kwe), .waddr(kwa), .wdata(kwd), .raddr(ra), .rdata(krd));
  lrft_ram #(.WIDTH(STAT_W), .DEPTH(ENTRIES)) u_fade (
    .clk, .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(ra), .rdata(frd));

  logic [SLOT_W-1:0] slot;
  assign slot = idx_r[SLOT_W-1:0];
  assign ra = slot;

  // input key normalization
  logic [2:0] lv_in;
  always_comb begin
    lv_in = in_tile_level;
    if (int'(in_tile_level) > LEVELS - 1) lv_in = 3'(LEVELS - 1);
  end

  // per-slot fade update and result kind
  logic [16:0] fsum;
  logic [15:0] fnew;
  logic sl, rs;
  kind_t skind;
  always_comb begin
    sl = sel_r[slot];
    rs = res_r[slot];
    fsum = {1'b0, frd} + {1'b0, step_r};
    fnew = frd;
    if (sl && rs) fnew = fsum[16] ? FADE_FULL : fsum[15:0];
    else if (!sl) fnew = (frd > step_r) ? frd - step_r : 16'd0;
    skind = K_DONE;
    if (rs && fnew != 16'd0) skind = K_DRAW;
    else if (sl && !rs) skind = K_PENDING;
    else if (!sl && fnew == 16'd0 && rs) skind = K_RELEASE;
  end

  // output register free at the next edge, and when it gets loaded
  logic take, ov_load;
  assign take = !ov_r || out_ready;
  assign ov_load = take && (((state_r == S_EMIT) && (okind_r != K_DONE)) ||
                            (state_r == S_END));

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_out_level = okey_r[KEY_W-1 -: 3];
  assign out_out_x = 24'(okey_r[2*COORD_BITS-1 -: COORD_BITS]);
  assign out_out_z = 24'(okey_r[COORD_BITS-1:0]);
  assign out_fade_level = ofade_r;
  assign out_last = olast_r;

  logic key_hit;
  assign key_hit = vld_r[slot] && (krd == key_r);
  logic idx_end;
  assign idx_end = (idx_r == CNT_W'(ENTRIES - 1));

  always_comb begin
    kwe = 1'b0; kwa = free_slot_r; kwd = key_r;
    fwe = 1'b0; fwa = slot; fwd = fnew;
    if (state_r == S_END && op_t'(op_r) == OP_SELECT && !found_r && free_r) begin
      kwe = 1'b1; fwe = 1'b1; fwa = free_slot_r; fwd = 16'd0;
    end
    if (state_r == S_EVAL && op_t'(op_r) == OP_FINISH && vld_r[slot] && take)
      fwe = 1'b1;
  end

  // control and sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rate_r <= 16'd64; vld_r <= '0; sel_r <= '0; res_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) rate_r <= cfg_data;
      if (ov_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          op_r <= in_opcode;
          key_r <= {lv_in, in_tile_x[COORD_BITS-1:0], in_tile_z[COORD_BITS-1:0]};
          idx_r <= '0; found_r <= 1'b0; free_r <= 1'b0;
          state_r <= (op_t'(in_opcode) == OP_FINISH) ? S_STEP : S_RD;
          prod_r <= in_time_step * rate_r;
        end
        S_STEP: begin
          step_r <= (rate_r == 16'd0 || prod_r[31:16] != 16'd0) ? FADE_FULL : prod_r[15:0];
          state_r <= S_RD;
        end
        S_RD: state_r <= S_EVAL;
        S_EVAL: begin
          if (op_t'(op_r) == OP_FINISH) begin
            if (vld_r[slot]) begin
              // wait for the output register before touching the slot
              if (take) begin
                okey_r <= krd; okind_r <= skind; olast_r <= 1'b0;
                ofade_r <= (skind == K_DRAW) ? fnew : 16'd0;
                if (!sl && fnew == 16'd0) begin
                  vld_r[slot] <= 1'b0; res_r[slot] <= 1'b0;
                end
                sel_r[slot] <= 1'b0;
                state_r <= S_EMIT;
              end
            end else begin
              state_r <= idx_end ? S_END : S_RD;
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            if (key_hit && !found_r) begin
              found_r <= 1'b1; fslot_r <= slot;
            end
            if (!vld_r[slot] && !free_r) begin
              free_r <= 1'b1; free_slot_r <= slot;
            end
            state_r <= idx_end ? S_END : S_RD;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EMIT: if (take) begin
          state_r <= idx_end ? S_END : S_RD;
          idx_r <= idx_r + 1'b1;
        end
        S_END: if (take) begin
          olast_r <= 1'b1; ofade_r <= 16'd0;
          okey_r <= (op_t'(op_r) == OP_FINISH) ? '0 : key_r;
          state_r <= S_IDLE;
          case (op_t'(op_r))
            OP_SELECT: begin
              if (found_r) begin
                okind_r <= K_KNOWN; sel_r[fslot_r] <= 1'b1;
              end else if (free_r) begin
                okind_r <= K_LOAD; vld_r[free_slot_r] <= 1'b1;
                sel_r[free_slot_r] <= 1'b1; res_r[free_slot_r] <= 1'b0;
              end else okind_r <= K_FULL;
            end
            OP_MARK: begin
              if (found_r) begin
                okind_r <= K_MARKED; res_r[fslot_r] <= 1'b1;
              end else okind_r <= K_NOT_FOUND;
            end
            OP_QUERY: okind_r <= (found_r && res_r[fslot_r]) ? K_RESIDENT : K_ABSENT;
            default: okind_r <= K_DONE;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a result register is never overwritten while still waiting
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(okind_r)) else $error("result lost");
  // no new request while busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("accept while busy");
  // ending a request loads its closing result into the output register
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_END && (!ov_r || out_ready) |=> ov_r && olast_r)
    else $error("missing last");
`endif
endmodule
`default_nettype wire

// File: test/tb_lod_residency_fade_table_core.sv
// Testbench for lod_residency_fade_table_core: random and directed tile requests,
// a local table model predicting every result. Depends on lrft_pkg and the RTL.
`default_nettype none
module tb_lod_residency_fade_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lrft_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [2:0]  level;
    logic [23:0] x;
    logic [23:0] z;
    logic [15:0] dt;
  } tile_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  level;
    logic [23:0] x;
    logic [23:0] z;
    logic [15:0] fade;
    logic        last;
  } tile_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [2:0] in_tile_level = '0;
  logic signed [23:0] in_tile_x = '0;
  logic signed [23:0] in_tile_z = '0;
  logic [15:0] in_time_step = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_kind;
  logic [2:0] out_out_level;
  logic signed [23:0] out_out_x;
  logic signed [23:0] out_out_z;
  logic [15:0] out_fade_level;
  logic out_last;

  lod_residency_fade_table_core i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_tile_level,
    .in_tile_x, .in_tile_z, .in_time_step, .cfg_valid, .cfg_ready, .cfg_data,
    .out_valid, .out_ready, .out_kind, .out_out_level, .out_out_x, .out_out_z,
    .out_fade_level, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Table model state
  logic [15:0] rate_q;
  logic [2:0]  m_lv [ENTRIES];
  logic [23:0] m_x [ENTRIES];
  logic [23:0] m_z [ENTRIES];
  logic [15:0] m_fade [ENTRIES];
  logic        m_vld [ENTRIES];
  logic        m_sel [ENTRIES];
  logic        m_res [ENTRIES];

  tile_req_t pending_reqs[$];
  tile_res_t expected_res[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic tb_done = 1'b0;

  function automatic tile_res_t mk_res(kind_t k, logic [2:0] lv, logic [23:0] x,
                                       logic [23:0] z, logic [15:0] f, logic l);
    tile_res_t r;
    r.kind = k; r.level = lv; r.x = x; r.z = z; r.fade = f; r.last = l;
    return r;
  endfunction

  // queue helpers
  task automatic add_exp(tile_res_t r);
    expected_res.insert(expected_res.size(), r);
  endtask

  task automatic add_req(tile_req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  function automatic int find_tile(logic [2:0] lv, logic [23:0] x, logic [23:0] z);
    for (int i = 0; i < ENTRIES; i++)
      if (m_vld[i] && m_lv[i] == lv && m_x[i] == x && m_z[i] == z) return i;
    return -1;
  endfunction

  // Apply one accepted request to the model and queue its results
  task automatic predict_table(tile_req_t q);
    int s;
    int fr;
    logic [31:0] step;
    logic [16:0] f;
    s = find_tile(q.level, q.x, q.z);
    case (q.op)
      OP_SELECT: begin
        if (s >= 0) begin
          m_sel[s] = 1'b1;
          add_exp(mk_res(K_KNOWN, q.level, q.x, q.z, '0, 1'b1));
        end else begin
          fr = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) if (!m_vld[i]) fr = i;
          if (fr < 0) begin
            add_exp(mk_res(K_FULL, q.level, q.x, q.z, '0, 1'b1));
          end else begin
            m_vld[fr] = 1'b1; m_sel[fr] = 1'b1; m_res[fr] = 1'b0; m_fade[fr] = '0;
            m_lv[fr] = q.level; m_x[fr] = q.x; m_z[fr] = q.z;
            add_exp(mk_res(K_LOAD, q.level, q.x, q.z, '0, 1'b1));
          end
        end
      end
      OP_MARK: begin
        if (s >= 0) m_res[s] = 1'b1;
        add_exp(mk_res(s >= 0 ? K_MARKED : K_NOT_FOUND, q.level, q.x, q.z, '0, 1'b1));
      end
      OP_QUERY: begin
        add_exp(mk_res((s >= 0 && m_res[s]) ? K_RESIDENT : K_ABSENT,
                       q.level, q.x, q.z, '0, 1'b1));
      end
      default: begin
        step = (rate_q == 0) ? 32'hFFFF : q.dt * rate_q;
        if (step > 32'hFFFF) step = 32'hFFFF;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!m_vld[i]) continue;
          f = {1'b0, m_fade[i]};
          if (m_sel[i] && m_res[i]) begin
            f = f + step[15:0];
            if (f > 17'hFFFF) f = 17'hFFFF;
          end else if (!m_sel[i]) begin
            f = (f > step) ? f - step[15:0] : '0;
          end
          m_fade[i] = f[15:0];
          if (m_res[i] && f != 0)
            add_exp(mk_res(K_DRAW, m_lv[i], m_x[i], m_z[i], f[15:0], 1'b0));
          else if (m_sel[i] && !m_res[i])
            add_exp(mk_res(K_PENDING, m_lv[i], m_x[i], m_z[i], '0, 1'b0));
          else if (!m_sel[i] && f == 0 && m_res[i])
            add_exp(mk_res(K_RELEASE, m_lv[i], m_x[i], m_z[i], '0, 1'b0));
          if (!m_sel[i] && f == 0) begin
            m_vld[i] = 1'b0; m_res[i] = 1'b0;
          end
          m_sel[i] = 1'b0;
        end
        add_exp(mk_res(K_DONE, '0, '0, '0, '0, 1'b1));
      end
    endcase
  endtask

  // Driver: present next pending request, with random idle cycles and output stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_table({op_t'(in_opcode), in_tile_level,
                                               in_tile_x, in_tile_z, in_time_step});
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tile_req_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= q.op; in_tile_level <= q.level;
          in_tile_x <= q.x; in_tile_z <= q.z; in_time_step <= q.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, out_kind);
        errors++;
      end else begin
        tile_res_t e;
        e = expected_res.pop_front();
        if (out_kind != e.kind || out_out_level != e.level || out_out_x != e.x ||
            out_out_z != e.z || out_fade_level != e.fade || out_last != e.last) begin
          $display("%0t: mismatch exp k%0d l%0d x%h z%h f%h last%0d", $time,
                   e.kind, e.level, e.x, e.z, e.fade, e.last);
          $display("%0t:          got k%0d l%0d x%h z%h f%h last%0d", $time,
                   out_kind, out_out_level, out_out_x, out_out_z, out_fade_level,
                   out_last);
          errors++;
        end
      end
    end
  end

  // Small key pool so selects, marks and queries hit each other often
  tile_req_t key_pool[48];

  function automatic tile_req_t rand_req();
    tile_req_t q;
    int r;
    q = key_pool[$urandom_range(47)];
    r = $urandom_range(99);
    q.op = (r < 45) ? OP_SELECT : (r < 70) ? OP_MARK : (r < 85) ? OP_QUERY : OP_FINISH;
    q.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    if ($urandom_range(19) == 0) begin
      q.level = 3'($urandom); q.x = 24'($urandom); q.z = 24'($urandom);
    end
    return q;
  endfunction

  function automatic tile_req_t mk_req(op_t op, logic [2:0] lv, logic [23:0] x,
                                       logic [23:0] z, logic [15:0] dt);
    tile_req_t q;
    q.op = op; q.level = lv; q.x = x; q.z = z; q.dt = dt;
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (2 * ENTRIES + 10) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    rate_q = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) add_req(rand_req());
    wait_drained();
  endtask

  initial begin
    rate_q = 16'd64;
    for (int i = 0; i < ENTRIES; i++) begin
      m_vld[i] = 0; m_sel[i] = 0; m_res[i] = 0; m_fade[i] = 0;
      m_lv[i] = 0; m_x[i] = 0; m_z[i] = 0;
    end
    for (int i = 0; i < 48; i++)
      key_pool[i] = mk_req(OP_SELECT, 3'($urandom), 24'($urandom), 24'($urandom), '0);
    key_pool[0] = mk_req(OP_SELECT, 3'd7, 24'h7FFFFF, 24'h800000, '0);
    key_pool[1] = mk_req(OP_SELECT, 3'd0, 24'h000000, 24'hFFFFFF, '0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every opcode, unknown keys, fill table to full
    add_req(mk_req(OP_QUERY, 3'd7, 24'h7FFFFF, 24'h800000, '0));
    add_req(mk_req(OP_MARK, 3'd7, 24'h7FFFFF, 24'h800000, '0));
    add_req(mk_req(OP_SELECT, 3'd7, 24'h7FFFFF, 24'h800000, '0));
    add_req(mk_req(OP_SELECT, 3'd7, 24'h7FFFFF, 24'h800000, '0));
    add_req(mk_req(OP_SELECT, 3'd0, 24'h000000, 24'hFFFFFF, '0));
    add_req(mk_req(OP_MARK, 3'd7, 24'h7FFFFF, 24'h800000, '0));
    add_req(mk_req(OP_QUERY, 3'd7, 24'h7FFFFF, 24'h800000, '0));
    add_req(mk_req(OP_FINISH, '0, '0, '0, 16'hFFFF));
    add_req(mk_req(OP_FINISH, 3'd5, 24'h123456, 24'hABCDEF, 16'd0));
    add_req(mk_req(OP_FINISH, '0, '0, '0, 16'hFFFF));
    for (int i = 0; i < 12; i++)
      add_req(mk_req(OP_SELECT, 3'($urandom), 24'($urandom), 24'($urandom), '0));
    wait_drained();
    for (int i = 0; i < 34; i++)
      add_req(mk_req(OP_SELECT, 3'($urandom), 24'($urandom), 24'($urandom), '0));
    add_req(mk_req(OP_FINISH, '0, '0, '0, 16'd1));
    add_req(mk_req(OP_FINISH, '0, '0, '0, 16'd0));
    wait_drained();

    // Random phases with different rates and idling
    write_rate(16'd0);
    run_random(50);
    // Hold-off: sender idles on about 66 percent of cycles
    write_rate(16'hFFFF);
    send_idle_pct = 66;
    run_random(50);
    write_rate(16'd1);
    send_idle_pct = 0; recv_stall_pct = 66;
    run_random(50);
    write_rate(16'd3000);
    send_idle_pct = 10; recv_stall_pct = 10;
    run_random(50);
    write_rate(16'($urandom));
    send_idle_pct = 0; recv_stall_pct = 0;
    run_random(50);

    if (errors == 0 && expected_res.size() == 0)
      $display("tb_lod_residency_fade_table_core OK");
    else
      $display("tb_lod_residency_fade_table_core NOT OK");
    tb_done = 1'b1;
    $finish;
  end

  initial begin
    #20ms;
    if (!tb_done) begin
      $display("%0t: timeout", $time);
      $display("tb_lod_residency_fade_table_core NOT OK");
      $finish;
    end
  end
endmodule
`default_nettype wire
